[hdl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// Types, constants and helpers shared by the sprite frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  localparam int unsigned ROWS             = 10;
  localparam int unsigned FRAME_COUNT_BITS = 6;

  localparam int unsigned FRAME_W   = 6;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned ALPHA_W   = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned FCOUNTS_W = 60;
  localparam int unsigned NF_W      = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 60;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OSCILLATE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ROWS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNTS = 3'd5;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd50;
  localparam logic [ROW_W-1:0]    ROW_COUNT_RESET = 4'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;
  localparam int unsigned        FADE_SHIFT = 7;

  // divider: numerator holds nf * 128 + count - 1, two quotient bits a cycle
  localparam int unsigned DIV_NUM_W     = 14;
  localparam int unsigned DIV_DEN_W     = FRAME_COUNT_BITS;
  localparam int unsigned DIV_BITS_STEP = 2;
  localparam int unsigned DIV_CYCLES    = DIV_NUM_W / DIV_BITS_STEP;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_CYCLES);

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [PERIOD_W-1:0]  frame_period_ms;
    logic                 oscillate_mode;
    logic                 wrap_rows;
    logic                 fade_mode;
    logic [ROW_W-1:0]     row_count;
    logic [FCOUNTS_W-1:0] frame_counts;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] now_ms;
    logic [ROW_W-1:0]  start_row;
    logic              loop_request;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  last_step_time;
    logic [FRAME_W-1:0] frame_index;
    logic [ROW_W-1:0]   row_index;
    logic               going_down;
    logic               animating;
    logic               loop_flag;
  } anim_state_t;

  typedef struct packed {
    logic                 stepped;
    logic                 finished;
    logic                 alpha_valid;
    logic                 alpha_full;
    logic                 div_req;
    logic [DIV_NUM_W-1:0] numer;
    logic [DIV_DEN_W-1:0] denom;
  } step_info_t;

  function automatic logic [FRAME_COUNT_BITS-1:0] count_of(
    input logic [FCOUNTS_W-1:0] counts,
    input logic [ROW_W-1:0]     row
  );
    logic [FRAME_COUNT_BITS-1:0] res;
    res = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (row == ROW_W'(i) && (i + 1) * FRAME_COUNT_BITS <= FCOUNTS_W) begin
        res = counts[i*FRAME_COUNT_BITS +: FRAME_COUNT_BITS];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/sprite_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite animation sequencer: advances frame and row on time ticks, derives
// a fade alpha, and returns one status word for every input word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per tick or start; tuser is the opcode (tick or
//   start), tdata holds now_ms, start_row and loop_request.
//   m_axis returns one status word per input word: frame, row, alpha,
//   alpha_valid, stepped, finished and running.
//   cfg writes one register per handshake; cfg_ready_o is always high.
//   Write configuration only while no word is in flight.
// Word flow:
//   An accepted word is registered, its next state is computed in the CALC
//   state and its status word is written to the output register from the
//   OUT state; the next word is taken only after that, back in idle. A fade
//   step adds the iterative divider (DIV state) between CALC and OUT. The
//   divider yields two quotient bits a cycle.
//   s_axis_tready is high only while the sequencer is idle.
// Reset: registers take their reset values, animation stopped, loop set.
// Stall: the output register holds its word while m_axis_tready is low; the
//   next input word is still taken and its result waits in the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // cfg
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // now_ms[31:0], start_row[35:32], loop_request[36], zero fill
  input  wire logic [sfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic                            s_axis_tuser,
  // output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // frame[5:0], row[9:6], alpha[17:10], alpha_valid[18], stepped[19],
  // finished[20], running[21], zero fill
  output logic [sfs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import sfs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e      state_q;
  cfg_t        cfg_q;
  item_t       item_q;
  anim_state_t anim_q;
  step_info_t  info_q;
  anim_state_t anim_nxt;
  step_info_t  info_nxt;

  logic                     out_valid_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;
  logic                     in_fire;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_NUM_W-1:0]     div_quot;
  logic [ALPHA_W-1:0]       alpha;
  logic                     out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign div_start     = (state_q == ST_CALC) && info_nxt.div_req;

  sfs_step u_step (
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .cur_i  (anim_q),
    .nxt_o  (anim_nxt),
    .info_o (info_nxt)
  );

  sfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (info_nxt.numer),
    .denom_i (info_nxt.denom),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    if (!info_q.alpha_valid) begin
      alpha = '0;
    end else if (info_q.alpha_full) begin
      alpha = ALPHA_FULL;
    end else if (div_quot > DIV_NUM_W'(ALPHA_FULL)) begin
      alpha = '0;
    end else begin
      alpha = ALPHA_W'(ALPHA_FULL - div_quot[ALPHA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_period_ms <= PERIOD_RESET;
      cfg_q.oscillate_mode  <= 1'b0;
      cfg_q.wrap_rows       <= 1'b0;
      cfg_q.fade_mode       <= 1'b0;
      cfg_q.row_count       <= ROW_COUNT_RESET;
      cfg_q.frame_counts    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_PERIOD: cfg_q.frame_period_ms <= cfg_data_i[PERIOD_W-1:0];
        REG_OSCILLATE:    cfg_q.oscillate_mode  <= cfg_data_i[0];
        REG_WRAP_ROWS:    cfg_q.wrap_rows       <= cfg_data_i[0];
        REG_FADE_MODE:    cfg_q.fade_mode       <= cfg_data_i[0];
        REG_ROW_COUNT:    cfg_q.row_count       <= cfg_data_i[ROW_W-1:0];
        REG_FRAME_COUNTS: cfg_q.frame_counts    <= cfg_data_i[FCOUNTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= ST_IDLE;
      item_q                <= '0;
      anim_q.last_step_time <= '0;
      anim_q.frame_index    <= '0;
      anim_q.row_index      <= '0;
      anim_q.going_down     <= 1'b0;
      anim_q.animating      <= 1'b0;
      anim_q.loop_flag      <= 1'b1;
      info_q                <= '0;
      out_valid_q           <= 1'b0;
      out_data_q            <= '0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            item_q.opcode       <= s_axis_tuser;
            item_q.now_ms       <= s_axis_tdata[TIME_W-1:0];
            item_q.start_row    <= s_axis_tdata[TIME_W +: ROW_W];
            item_q.loop_request <= s_axis_tdata[TIME_W+ROW_W];
            state_q             <= ST_CALC;
          end
        end
        ST_CALC: begin
          anim_q  <= anim_nxt;
          info_q  <= info_nxt;
          state_q <= info_nxt.div_req ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_data_q  <= {2'b00, anim_q.animating, info_q.finished, info_q.stepped,
                            info_q.alpha_valid, alpha, anim_q.row_index,
                            anim_q.frame_index};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_alpha_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[18]) |-> (m_axis_tdata[17:10] == '0))
    else $error("alpha set without alpha_valid");

  a_finished_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[20]) |->
      (!m_axis_tdata[21] && m_axis_tdata[9:0] == '0))
    else $error("finished word not at row 0 frame 0 stopped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input taken again before the word was processed");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

`default_nettype wire

[hdl/sfs_div.sv]
// ----------------------------------------------------------------------------
// sfs_div
// Iterative restoring divider for the fade alpha, two quotient bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sfs_pkg::DIV_NUM_W-1:0] numer_i,
  input  wire logic [sfs_pkg::DIV_DEN_W-1:0] denom_i,
  output logic                               done_o,
  output logic [sfs_pkg::DIV_NUM_W-1:0]      quot_o
);
  import sfs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_NUM_W-1:0] quot_q, quot_d;

  logic [DIV_DEN_W:0]   r1, r2;
  logic [DIV_DEN_W-1:0] r1s, r2s;
  logic                 ge1, ge2;

  always_comb begin
    r1  = {rem_q, num_q[DIV_NUM_W-1]};
    ge1 = r1 >= {1'b0, den_q};
    r1s = ge1 ? DIV_DEN_W'(r1 - {1'b0, den_q}) : r1[DIV_DEN_W-1:0];
    r2  = {r1s, num_q[DIV_NUM_W-2]};
    ge2 = r2 >= {1'b0, den_q};
    r2s = ge2 ? DIV_DEN_W'(r2 - {1'b0, den_q}) : r2[DIV_DEN_W-1:0];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = denom_i;
      num_d  = numer_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = r2s;
      num_d  = {num_q[DIV_NUM_W-DIV_BITS_STEP-1:0], {DIV_BITS_STEP{1'b0}}};
      quot_d = {quot_q[DIV_NUM_W-DIV_BITS_STEP-1:0], ge1, ge2};
      cnt_d  = DIV_CNT_W'(cnt_q + 1'b1);
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[hdl/sfs_step.sv]
// ----------------------------------------------------------------------------
// sfs_step
// Next animation state for one word: start handling, time compare, frame
// advance, turns, row wrapping and the fade division request.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_step (
  input  wire sfs_pkg::cfg_t        cfg_i,
  input  wire sfs_pkg::item_t       item_i,
  input  wire sfs_pkg::anim_state_t cur_i,
  output sfs_pkg::anim_state_t      nxt_o,
  output sfs_pkg::step_info_t       info_o
);
  import sfs_pkg::*;

  logic [FRAME_COUNT_BITS-1:0] cnt;
  logic [TIME_W-1:0]           elapsed;
  logic [NF_W-1:0]             nf;
  logic                        neg;
  logic                        row_end;
  logic [ROW_W-1:0]            row_inc;

  always_comb begin
    cnt     = count_of(cfg_i.frame_counts, cur_i.row_index);
    elapsed = item_i.now_ms - cur_i.last_step_time;
    neg     = cur_i.going_down && (cur_i.frame_index == '0);
    nf      = cur_i.going_down ? NF_W'({2'b00, cur_i.frame_index} - 8'd1)
                               : NF_W'({2'b00, cur_i.frame_index} + 8'd1);
    row_end = neg || nf[FRAME_W] || (nf[FRAME_W-1:0] >= cnt);
    row_inc = ROW_W'(cur_i.row_index + 1'b1);

    nxt_o              = cur_i;
    info_o             = '0;
    info_o.denom       = cnt;
    info_o.numer       = DIV_NUM_W'({nf[FRAME_W:0], {FADE_SHIFT{1'b0}}})
                       + DIV_NUM_W'(cnt) - DIV_NUM_W'(1);

    if (item_i.opcode == OP_START) begin
      nxt_o.row_index    = item_i.start_row;
      nxt_o.frame_index  = '0;
      nxt_o.animating    = 1'b1;
      nxt_o.loop_flag    = item_i.loop_request;
      info_o.alpha_valid = 1'b1;
      info_o.alpha_full  = 1'b1;
    end else if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cfg_i.frame_period_ms}) begin
      info_o.stepped       = 1'b1;
      nxt_o.last_step_time = item_i.now_ms;
      if (cur_i.animating) begin
        if (cfg_i.fade_mode && cnt != '0) begin
          info_o.alpha_valid = 1'b1;
          info_o.alpha_full  = neg;
          info_o.div_req     = !neg;
        end
        if (cfg_i.oscillate_mode) begin
          if (!cur_i.going_down) begin
            if (nf >= {2'b00, cnt}) begin
              nxt_o.frame_index = (cnt == '0) ? '0 : FRAME_W'(cnt - 1'b1);
              nxt_o.going_down  = 1'b1;
            end else begin
              nxt_o.frame_index = nf[FRAME_W-1:0];
            end
          end else if (cur_i.frame_index <= FRAME_W'(1)) begin
            nxt_o.frame_index = '0;
            nxt_o.going_down  = 1'b0;
            nxt_o.animating   = cur_i.loop_flag;
          end else begin
            nxt_o.frame_index = nf[FRAME_W-1:0];
          end
        end else if (row_end) begin
          nxt_o.frame_index = '0;
          if (cfg_i.wrap_rows) begin
            if (row_inc >= cfg_i.row_count) begin
              nxt_o.row_index = '0;
              nxt_o.animating = cur_i.loop_flag;
              info_o.finished = !cur_i.loop_flag;
            end else begin
              nxt_o.row_index = row_inc;
            end
          end else begin
            nxt_o.animating = cur_i.loop_flag;
            if (!cur_i.loop_flag) begin
              nxt_o.row_index = '0;
              info_o.finished = 1'b1;
            end
          end
        end else begin
          nxt_o.frame_index = nf[FRAME_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/tb_sprite_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer
// Drives tick and start words into the sprite frame sequencer under a range
// of register settings, with random gaps on both streams, and checks every
// status word against an in-bench model of the frame, row and fade logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sprite_frame_sequencer;
  import sfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int unsigned          SETTLE_CYCLES = 24;
  localparam int unsigned          STALL_LIMIT   = 2000;
  localparam int unsigned          PHASES        = 12;
  localparam int unsigned          PHASE_WORDS   = 152;

  typedef struct packed {
    logic               running;
    logic               finished;
    logic               stepped;
    logic               alpha_valid;
    logic [ALPHA_W-1:0] alpha;
    logic [ROW_W-1:0]   row;
    logic [FRAME_W-1:0] frame;
  } status_t;

  class sprite_tracker;
    logic [PERIOD_W-1:0]  period;
    logic                 osc;
    logic                 wrap;
    logic                 fade;
    logic [ROW_W-1:0]     row_count;
    logic [FCOUNTS_W-1:0] counts;
    logic [TIME_W-1:0]    last_step;
    logic [FRAME_W-1:0]   frame;
    logic [ROW_W-1:0]     row;
    logic                 going_down;
    logic                 animating;
    logic                 loop_flag;
    status_t              status_due[$];
    int unsigned          mismatches;
    int unsigned          words_seen;

    function new();
      period     = PERIOD_RESET;
      osc        = 1'b0;
      wrap       = 1'b0;
      fade       = 1'b0;
      row_count  = ROW_COUNT_RESET;
      counts     = '0;
      last_step  = '0;
      frame      = '0;
      row        = '0;
      going_down = 1'b0;
      animating  = 1'b0;
      loop_flag  = 1'b1;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_PERIOD: period    = data[PERIOD_W-1:0];
        REG_OSCILLATE:    osc       = data[0];
        REG_WRAP_ROWS:    wrap      = data[0];
        REG_FADE_MODE:    fade      = data[0];
        REG_ROW_COUNT:    row_count = data[ROW_W-1:0];
        REG_FRAME_COUNTS: counts    = data[FCOUNTS_W-1:0];
        default: ;
      endcase
    endfunction

    function int frames_in_row(logic [ROW_W-1:0] r);
      if (r >= ROWS) return 0;
      return int'(counts[r*FRAME_COUNT_BITS +: FRAME_COUNT_BITS]);
    endfunction

    function void note_word(logic op, logic [TIME_W-1:0] now, logic [ROW_W-1:0] srow,
                            logic lp);
      status_t           s;
      logic [TIME_W-1:0] elapsed;
      int                cnt;
      int                nf;
      int                q;
      logic              at_end;
      s = '0;
      elapsed = now - last_step;
      if (op == OP_START) begin
        row = srow;
        frame = '0;
        animating = 1'b1;
        loop_flag = lp;
        s.alpha = ALPHA_FULL;
        s.alpha_valid = 1'b1;
      end else if (elapsed >= TIME_W'(period)) begin
        s.stepped = 1'b1;
        last_step = now;
        if (animating) begin
          cnt = frames_in_row(row);
          nf = going_down ? int'(frame) - 1 : int'(frame) + 1;
          if (fade && cnt != 0) begin
            s.alpha_valid = 1'b1;
            if (nf < 0) begin
              s.alpha = ALPHA_FULL;
            end else begin
              q = (128 * nf + cnt - 1) / cnt;
              s.alpha = (q > 255) ? '0 : ALPHA_W'(255 - q);
            end
          end
          if (osc) begin
            if (!going_down) begin
              if (nf >= cnt) begin
                frame = (cnt == 0) ? '0 : FRAME_W'(cnt - 1);
                going_down = 1'b1;
              end else begin
                frame = FRAME_W'(nf);
              end
            end else if (nf <= 0) begin
              frame = '0;
              going_down = 1'b0;
              animating = loop_flag;
            end else begin
              frame = FRAME_W'(nf);
            end
          end else begin
            // below zero wraps to the top frame, which is always past the row
            at_end = (nf < 0) || (nf > 63) || (nf >= cnt);
            if (!at_end) begin
              frame = FRAME_W'(nf);
            end else begin
              frame = '0;
              if (wrap) begin
                row = row + 1'b1;
                if (row >= row_count) begin
                  row = '0;
                  animating = loop_flag;
                  s.finished = !loop_flag;
                end
              end else begin
                animating = loop_flag;
                if (!loop_flag) begin
                  row = '0;
                  s.finished = 1'b1;
                end
              end
            end
          end
        end
      end
      s.frame = frame;
      s.row = row;
      s.running = animating;
      status_due.push_back(s);
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH word %0d: %s", words_seen, msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_status(logic [OUT_TDATA_W-1:0] word);
      status_t want;
      status_t got;
      words_seen++;
      if (status_due.size() == 0) begin
        report($sformatf("status word 0x%h with nothing expected", word));
        return;
      end
      want = status_due.pop_front();
      got = word[$bits(status_t)-1:0];
      compare_field("frame", got.frame, want.frame);
      compare_field("row", got.row, want.row);
      compare_field("alpha", got.alpha, want.alpha);
      compare_field("alpha_valid", got.alpha_valid, want.alpha_valid);
      compare_field("stepped", got.stepped, want.stepped);
      compare_field("finished", got.finished, want.finished);
      compare_field("running", got.running, want.running);
      compare_field("fill", word[OUT_TDATA_W-1:$bits(status_t)], 0);
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  sprite_tracker     tracker = new();
  logic              jittered = 1'b1;
  logic [TIME_W-1:0] clock_ms = '0;
  int unsigned       quiet_cycles = 0;

  sprite_frame_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [CFG_DATA_W-1:0] padded(logic [CFG_DATA_W-1:0] value, int w);
    logic [CFG_DATA_W-1:0] fill;
    fill = CFG_DATA_W'({$urandom, $urandom});
    return ($urandom_range(0, 1) == 1) ? (value | (fill << w)) : value;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_setting(input logic [PERIOD_W-1:0] period, input logic osc,
                              input logic wrap, input logic fade,
                              input logic [ROW_W-1:0] rows,
                              input logic [FCOUNTS_W-1:0] counts);
    write_reg(REG_FRAME_PERIOD, padded(CFG_DATA_W'(period), PERIOD_W));
    write_reg(REG_OSCILLATE, padded(CFG_DATA_W'(osc), 1));
    write_reg(REG_WRAP_ROWS, padded(CFG_DATA_W'(wrap), 1));
    write_reg(REG_FADE_MODE, padded(CFG_DATA_W'(fade), 1));
    write_reg(REG_ROW_COUNT, padded(CFG_DATA_W'(rows), ROW_W));
    write_reg(REG_FRAME_COUNTS, CFG_DATA_W'(counts));
    if ($urandom_range(0, 2) == 0)
      write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_word(input logic op, input logic [TIME_W-1:0] now,
                           input logic [ROW_W-1:0] srow, input logic lp);
    int gap;
    gap = jittered ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, lp, srow, now};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_word(op, now, srow, lp);
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] now);
    send_word(OP_TICK, now, ROW_W'($urandom), 1'($urandom));
  endtask

  task automatic send_start(input logic [ROW_W-1:0] srow, input logic lp);
    send_word(OP_START, $urandom, srow, lp);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.status_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : status_sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = jittered ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_status(m_axis_tdata);
    end
  end

  initial begin : word_source
    logic [PERIOD_W-1:0]  period;
    logic [ROW_W-1:0]     rows;
    logic [FCOUNTS_W-1:0] counts;
    logic [TIME_W-1:0]    delta;
    logic [ROW_W-1:0]     srow;
    logic                 go;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: period 50, no frames anywhere
    send_tick('0);
    send_tick('1);
    send_start(4'hF, 1'b1);
    send_tick(32'h0000_0031);
    send_start(4'd9, 1'b0);
    send_tick(32'h0000_0062);
    send_tick(32'h0000_0063);
    settle();

    // ping-pong with fade: rows of 2, 0 and 63 frames
    clock_ms = 32'h0000_1000;
    load_setting('0, 1'b1, 1'b0, 1'b1, 4'd1, FCOUNTS_W'(2) | (FCOUNTS_W'(63) << 12));
    send_start(4'd0, 1'b0);
    repeat (4) begin
      clock_ms = clock_ms + 1;
      send_tick(clock_ms);
    end
    send_start(4'd1, 1'b1);
    repeat (2) begin
      clock_ms = clock_ms + 1;
      send_tick(clock_ms);
    end
    send_start(4'd2, 1'b1);
    send_tick(clock_ms);
    send_start(4'd0, 1'b1);
    repeat (2) send_tick(clock_ms);
    settle();

    // leave ping-pong while counting down, row wrap with no rows in use
    load_setting('0, 1'b0, 1'b1, 1'b0, 4'd0, FCOUNTS_W'(2) | (FCOUNTS_W'(63) << 12));
    repeat (3) send_tick(clock_ms);
    send_tick($urandom);
    settle();

    clock_ms = 32'hFFFF_F000;
    for (int p = 0; p < PHASES; p++) begin
      counts = '0;
      for (int r = 0; r < ROWS; r++) begin
        case ($urandom_range(0, 4))
          0:       counts[r*FRAME_COUNT_BITS +: FRAME_COUNT_BITS] = '0;
          1, 2:    counts[r*FRAME_COUNT_BITS +: FRAME_COUNT_BITS] =
                     FRAME_COUNT_BITS'($urandom_range(1, 4));
          3:       counts[r*FRAME_COUNT_BITS +: FRAME_COUNT_BITS] =
                     FRAME_COUNT_BITS'($urandom_range(0, 63));
          default: counts[r*FRAME_COUNT_BITS +: FRAME_COUNT_BITS] = '1;
        endcase
      end
      case ($urandom_range(0, 4))
        0:       period = '0;
        1:       period = PERIOD_W'($urandom_range(1, 3));
        2:       period = PERIOD_W'($urandom_range(0, 200));
        3:       period = '1;
        default: period = PERIOD_RESET;
      endcase
      rows = ($urandom_range(0, 3) == 0) ? ROW_W'($urandom) : ROW_W'($urandom_range(1, 10));
      if (p == 0) begin
        load_setting('1, 1'b1, 1'b1, 1'b1, '1, '1);
      end else if (p == 1) begin
        load_setting('0, 1'b0, 1'b0, 1'b0, '0, '0);
      end else begin
        load_setting(period, 1'($urandom), 1'($urandom), 1'($urandom), rows, counts);
      end
      jittered = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        go = tracker.animating ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 1) == 1);
        if (go) begin
          srow = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom) : ROW_W'($urandom_range(0, 9));
          send_start(srow, ($urandom_range(0, 3) != 0));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: delta = TIME_W'(tracker.period) + $urandom_range(0, 2);
            6, 7:             delta = $urandom_range(0, tracker.period);
            8:                delta = (tracker.period == 0) ? '0 : TIME_W'(tracker.period) - 1;
            default:          delta = $urandom;
          endcase
          clock_ms = clock_ms + delta;
          send_tick(clock_ms);
        end
      end
      settle();
    end

    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
